FILE: src/aci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_pkg: shared types and constants
// Field widths, the reflectivity clamp and the result record for the complex
// IOR converter.
// ----------------------------------------------------------------------------
package aci_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 25;
    localparam int FRAC_BITS = 16;

    localparam logic [IN_W-1:0]  R_MAX   = 16'd64881;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic [OUT_W-1:0] index_red;
        logic [OUT_W-1:0] index_green;
        logic [OUT_W-1:0] index_blue;
        logic [OUT_W-1:0] extinct_red;
        logic [OUT_W-1:0] extinct_green;
        logic [OUT_W-1:0] extinct_blue;
    } ior_item_t;

endpackage
`default_nettype wire

FILE: src/aci_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_in_if: material channel
// Reflectivity and edge tint for three colour channels, one beat per item.
// ----------------------------------------------------------------------------
interface aci_in_if;
    import aci_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] reflect_red;
    logic [IN_W-1:0] reflect_green;
    logic [IN_W-1:0] reflect_blue;
    logic [IN_W-1:0] edge_red;
    logic [IN_W-1:0] edge_green;
    logic [IN_W-1:0] edge_blue;

    modport source (
        output valid, reflect_red, reflect_green, reflect_blue,
               edge_red, edge_green, edge_blue,
        input  ready
    );

    modport sink (
        input  valid, reflect_red, reflect_green, reflect_blue,
               edge_red, edge_green, edge_blue,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/aci_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_out_if: result channel
// Refractive index and extinction for three colour channels, one beat per item.
// ----------------------------------------------------------------------------
interface aci_out_if;
    import aci_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] index_red;
    logic [OUT_W-1:0] index_green;
    logic [OUT_W-1:0] index_blue;
    logic [OUT_W-1:0] extinct_red;
    logic [OUT_W-1:0] extinct_green;
    logic [OUT_W-1:0] extinct_blue;

    modport source (
        output valid, index_red, index_green, index_blue,
               extinct_red, extinct_green, extinct_blue,
        input  ready
    );

    modport sink (
        input  valid, index_red, index_green, index_blue,
               extinct_red, extinct_green, extinct_blue,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/aci_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_sqrt: pipelined integer square root
// Restoring square root, one root bit per register stage, with side data
// carried alongside.
// ----------------------------------------------------------------------------
module aci_sqrt #(
    parameter int X_W    = 64,
    parameter int SIDE_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X_W-1:0]    x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [X_W/2-1:0]  root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = X_W / 2;
    localparam int REM_W = STEPS + 2;

    logic              valid_reg [STEPS+1];
    logic [X_W-1:0]    x_reg     [STEPS+1];
    logic [REM_W-1:0]  rem_reg   [STEPS+1];
    logic [STEPS-1:0]  root_reg  [STEPS+1];
    logic [SIDE_W-1:0] side_reg  [STEPS+1];

    logic [X_W-1:0]    x_next    [STEPS];
    logic [REM_W-1:0]  rem_next  [STEPS];
    logic [STEPS-1:0]  root_next [STEPS];

    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] test;
        for (int j = 0; j < STEPS; j++)
        begin
            trial     = {rem_reg[j][REM_W-3:0], x_reg[j][X_W-1 -: 2]};
            test      = {root_reg[j], 2'b01};
            x_next[j] = x_reg[j] << 2;
            if (trial >= test)
            begin
                rem_next[j]  = trial - test;
                root_next[j] = {root_reg[j][STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = trial;
                root_next[j] = {root_reg[j][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= STEPS; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int j = 0; j < STEPS; j++)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int j = 0; j < STEPS; j++)
            begin
                x_reg[j+1]    <= x_next[j];
                rem_reg[j+1]  <= rem_next[j];
                root_reg[j+1] <= root_next[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign root      = root_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule
`default_nettype wire

FILE: src/aci_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_div: pipelined fixed-point divider
// Returns floor(a * 2^SH / b), one quotient bit per register stage, with side
// data carried alongside. The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module aci_div #(
    parameter int A_W    = 33,
    parameter int B_W    = 33,
    parameter int Q_W    = 41,
    parameter int SH     = 32,
    parameter int SIDE_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [A_W-1:0]    a,
    input  logic [B_W-1:0]    b,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] out_side
);
    localparam int R_W = B_W + 1;
    localparam int D_W = A_W + SH;

    logic [D_W-1:0] dvd;

    logic              valid_reg [Q_W+1];
    logic [R_W-1:0]    rem_reg   [Q_W+1];
    logic [Q_W-1:0]    lo_reg    [Q_W+1];
    logic [Q_W-1:0]    q_reg     [Q_W+1];
    logic [B_W-1:0]    b_reg     [Q_W+1];
    logic [SIDE_W-1:0] side_reg  [Q_W+1];

    logic [R_W-1:0]    rem_next  [Q_W];
    logic [Q_W-1:0]    lo_next   [Q_W];
    logic [Q_W-1:0]    q_next    [Q_W];

    assign dvd = {a, {SH{1'b0}}};

    always_comb
    begin
        logic [R_W-1:0] trial;
        for (int j = 0; j < Q_W; j++)
        begin
            trial      = {rem_reg[j][R_W-2:0], lo_reg[j][Q_W-1]};
            lo_next[j] = lo_reg[j] << 1;
            if (trial >= {1'b0, b_reg[j]})
            begin
                rem_next[j] = trial - {1'b0, b_reg[j]};
                q_next[j]   = {q_reg[j][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = trial;
                q_next[j]   = {q_reg[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= Q_W; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int j = 0; j < Q_W; j++)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= R_W'(dvd >> Q_W);
            lo_reg[0]   <= Q_W'(dvd);
            q_reg[0]    <= '0;
            b_reg[0]    <= b;
            side_reg[0] <= in_side;
            for (int j = 0; j < Q_W; j++)
            begin
                rem_reg[j+1]  <= rem_next[j];
                lo_reg[j+1]   <= lo_next[j];
                q_reg[j+1]    <= q_next[j];
                b_reg[j+1]    <= b_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule
`default_nettype wire

FILE: src/aci_chan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_chan: one colour channel
// Reflectivity and edge tint to refractive index and extinction through a
// root, two parallel dividers, the blend, a third divider and a final root.
// ----------------------------------------------------------------------------
module aci_chan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [aci_pkg::IN_W-1:0]  reflect,
    input  logic [aci_pkg::IN_W-1:0]  tint,
    output logic                    out_valid,
    output logic [aci_pkg::OUT_W-1:0] index,
    output logic [aci_pkg::OUT_W-1:0] extinct
);
    import aci_pkg::*;

    localparam int FX      = 32;
    localparam int K_FRAC  = 24;
    localparam int KSH     = FX - K_FRAC;
    localparam int X_W     = 64;
    localparam int S_W     = X_W / 2;
    localparam int D_W     = FX + 1;
    localparam int NQ_W    = 41;
    localparam int N_W     = 41;
    localparam int PMAX_W  = NQ_W + IN_W + 1;
    localparam int PMIN_W  = D_W + IN_W;
    localparam int M_W     = N_W + IN_W;
    localparam int NH_W    = N_W - FX;
    localparam int NLL_W   = 2 * FX;
    localparam int NHL_W   = NH_W + FX;
    localparam int NHH_W   = 2 * NH_W;
    localparam int MUL_W   = N_W + 1;
    localparam int A3_W    = MUL_W + 1;
    localparam int K2Q_W   = 50;
    localparam int SUB_W   = K2Q_W + 1;
    localparam int KQ_W    = S_W + KSH;
    localparam int BIG_BIT = X_W - 2 * KSH;
    localparam int N_SHIFT = FX - FRAC_BITS;
    localparam int K_SHIFT = K_FRAC - FRAC_BITS;

    localparam logic [D_W-1:0]  ONE_FX = {1'b1, {FX{1'b0}}};
    localparam logic [IN_W:0]   ONE_G  = {1'b1, {IN_W{1'b0}}};

    function automatic logic [OUT_W-1:0] sat_out(input logic [X_W-1:0] v);
        return (v > X_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    logic [IN_W-1:0] r_clamp;

    logic              s1_valid;
    logic [S_W-1:0]    s1_root;
    logic [2*IN_W-1:0] s1_side;
    logic [IN_W-1:0]   s1_r;
    logic [IN_W-1:0]   s1_g;
    logic [FX-1:0]     s1_r32;
    logic [D_W-1:0]    nmin_a;
    logic [D_W-1:0]    nmin_b;
    logic [D_W-1:0]    nmax_a;
    logic [D_W-1:0]    nmax_b;

    logic              dmin_valid;
    logic [NQ_W-1:0]   dmin_q;
    logic [IN_W-1:0]   dmin_g;
    logic              dmax_valid;
    logic [NQ_W-1:0]   dmax_q;
    logic [IN_W-1:0]   dmax_r;
    logic [IN_W:0]     w_max;

    logic              b1_valid_reg;
    logic [PMAX_W-1:0] pmax_reg;
    logic [PMIN_W-1:0] pmin_reg;
    logic [IN_W-1:0]   b1_r_reg;
    logic [PMAX_W-1:0] blend_sum;

    logic              b2_valid_reg;
    logic [N_W-1:0]    n_reg;
    logic [IN_W-1:0]   b2_r_reg;

    logic              b3_valid_reg;
    logic [M_W-1:0]    m_reg;
    logic [NLL_W-1:0]  nll_reg;
    logic [NHL_W-1:0]  nhl_reg;
    logic [NHH_W-1:0]  nhh_reg;
    logic [N_W-1:0]    b3_n_reg;
    logic [IN_W-1:0]   b3_r_reg;

    logic [MUL_W-1:0]  mul1;
    logic [A3_W-1:0]   a3;
    logic [SUB_W-1:0]  sub;
    logic [D_W-1:0]    b3;

    logic              d3_valid;
    logic [K2Q_W-1:0]  d3_q;
    logic [SUB_W+N_W-1:0] d3_side;
    logic [SUB_W-1:0]  d3_sub;
    logic [N_W-1:0]    d3_n;

    logic              b5_valid_reg;
    logic [K2Q_W-1:0]  k2_reg;
    logic [N_W-1:0]    b5_n_reg;
    logic              big;
    logic [X_W-1:0]    x2;

    logic              s2_valid;
    logic [S_W-1:0]    s2_root;
    logic [N_W:0]      s2_side;
    logic [KQ_W-1:0]   kq;

    logic              b6_valid_reg;
    logic [OUT_W-1:0]  index_reg;
    logic [OUT_W-1:0]  extinct_reg;

    assign r_clamp = (reflect > R_MAX) ? R_MAX : reflect;

    aci_sqrt #(
        .X_W    (X_W),
        .SIDE_W (2 * IN_W)
    ) u_sqrt_refl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x         ({r_clamp, {(X_W-IN_W){1'b0}}}),
        .in_side   ({r_clamp, tint}),
        .out_valid (s1_valid),
        .root      (s1_root),
        .out_side  (s1_side)
    );

    assign s1_r   = s1_side[2*IN_W-1:IN_W];
    assign s1_g   = s1_side[IN_W-1:0];
    assign s1_r32 = {s1_r, {(FX-IN_W){1'b0}}};
    assign nmin_a = ONE_FX - {1'b0, s1_r32};
    assign nmin_b = ONE_FX + {1'b0, s1_r32};
    assign nmax_a = ONE_FX + {1'b0, s1_root};
    assign nmax_b = ONE_FX - {1'b0, s1_root};

    aci_div #(
        .A_W    (D_W),
        .B_W    (D_W),
        .Q_W    (NQ_W),
        .SH     (FX),
        .SIDE_W (IN_W)
    ) u_div_nmin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .a         (nmin_a),
        .b         (nmin_b),
        .in_side   (s1_g),
        .out_valid (dmin_valid),
        .quot      (dmin_q),
        .out_side  (dmin_g)
    );

    aci_div #(
        .A_W    (D_W),
        .B_W    (D_W),
        .Q_W    (NQ_W),
        .SH     (FX),
        .SIDE_W (IN_W)
    ) u_div_nmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .a         (nmax_a),
        .b         (nmax_b),
        .in_side   (s1_r),
        .out_valid (dmax_valid),
        .quot      (dmax_q),
        .out_side  (dmax_r)
    );

    assign w_max     = ONE_G - {1'b0, dmin_g};
    assign blend_sum = pmax_reg + PMAX_W'(pmin_reg);

    assign mul1 = {1'b0, b3_n_reg} + MUL_W'(m_reg >> IN_W);
    assign a3   = {mul1, 1'b0};
    assign sub  = (SUB_W'(nhh_reg) << FX) + (SUB_W'(nhl_reg) << 1)
                + SUB_W'(nll_reg >> FX) + SUB_W'(ONE_FX);
    assign b3   = ONE_FX - {1'b0, b3_r_reg, {(FX-IN_W){1'b0}}};

    aci_div #(
        .A_W    (A3_W),
        .B_W    (D_W),
        .Q_W    (K2Q_W),
        .SH     (FX),
        .SIDE_W (SUB_W + N_W)
    ) u_div_k2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b3_valid_reg),
        .a         (a3),
        .b         (b3),
        .in_side   ({sub, b3_n_reg}),
        .out_valid (d3_valid),
        .quot      (d3_q),
        .out_side  (d3_side)
    );

    assign d3_sub = d3_side[SUB_W+N_W-1:N_W];
    assign d3_n   = d3_side[N_W-1:0];

    assign big = |k2_reg[K2Q_W-1:BIG_BIT];
    assign x2  = big ? X_W'(k2_reg) : X_W'({k2_reg, {(2*KSH){1'b0}}});

    aci_sqrt #(
        .X_W    (X_W),
        .SIDE_W (N_W + 1)
    ) u_sqrt_k (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b5_valid_reg),
        .x         (x2),
        .in_side   ({big, b5_n_reg}),
        .out_valid (s2_valid),
        .root      (s2_root),
        .out_side  (s2_side)
    );

    assign kq = s2_side[N_W] ? {s2_root, {KSH{1'b0}}} : KQ_W'(s2_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= dmin_valid & dmax_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b5_valid_reg <= d3_valid;
            b6_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmax_reg    <= PMAX_W'(dmax_q) * PMAX_W'(w_max);
            pmin_reg    <= PMIN_W'(dmin_q[D_W-1:0]) * PMIN_W'(dmin_g);
            b1_r_reg    <= dmax_r;

            n_reg       <= N_W'(blend_sum >> IN_W);
            b2_r_reg    <= b1_r_reg;

            m_reg       <= M_W'(n_reg) * M_W'(b2_r_reg);
            nll_reg     <= NLL_W'(n_reg[FX-1:0]) * NLL_W'(n_reg[FX-1:0]);
            nhl_reg     <= NHL_W'(n_reg[N_W-1:FX]) * NHL_W'(n_reg[FX-1:0]);
            nhh_reg     <= NHH_W'(n_reg[N_W-1:FX]) * NHH_W'(n_reg[N_W-1:FX]);
            b3_n_reg    <= n_reg;
            b3_r_reg    <= b2_r_reg;

            k2_reg      <= ({1'b0, d3_q} > d3_sub) ? K2Q_W'({1'b0, d3_q} - d3_sub) : '0;
            b5_n_reg    <= d3_n;

            index_reg   <= sat_out(X_W'(s2_side[N_W-1:0] >> N_SHIFT));
            extinct_reg <= sat_out(X_W'(kq >> K_SHIFT));
        end
    end

    assign out_valid = b6_valid_reg;
    assign index     = index_reg;
    assign extinct   = extinct_reg;

endmodule
`default_nettype wire

FILE: src/aci_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aci_outbuf: output register with skid stage
// Holds the result beat for the sink and absorbs one more beat from the
// pipeline while the sink stalls.
// ----------------------------------------------------------------------------
module aci_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  aci_pkg::ior_item_t  up_item,
    output logic                up_ready,
    aci_out_if.source           dn
);
    import aci_pkg::*;

    logic      main_valid_reg;
    logic      main_valid_next;
    ior_item_t main_reg;
    ior_item_t main_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    ior_item_t skid_reg;
    ior_item_t skid_next;
    logic      up_fire;

    assign up_ready = !skid_valid_reg;
    assign up_fire  = up_valid && up_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || dn.ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = up_fire;
                main_next       = up_item;
            end
        end
        else if (up_fire)
        begin
            skid_valid_next = 1'b1;
            skid_next       = up_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign dn.valid         = main_valid_reg;
    assign dn.index_red     = main_reg.index_red;
    assign dn.index_green   = main_reg.index_green;
    assign dn.index_blue    = main_reg.index_blue;
    assign dn.extinct_red   = main_reg.extinct_red;
    assign dn.extinct_green = main_reg.extinct_green;
    assign dn.extinct_blue  = main_reg.extinct_blue;

    // skid never fills ahead of the output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage full while output register empty");

    // hold a beat that arrives during a stall
    a_stall_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (up_fire && main_valid_reg && !dn.ready) |=> skid_valid_reg)
        else $error("beat arriving during stall not captured");

    // drain the skid stage as soon as the sink takes a beat
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && dn.ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid stage not drained after sink took a beat");

endmodule
`default_nettype wire

FILE: src/artistic_complex_ior.sv
`default_nettype none
// ----------------------------------------------------------------------------
// artistic_complex_ior: artistic complex IOR converter
// Reflectivity and edge tint per colour channel to a conductor's refractive
// index and extinction, three channels side by side.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the skid stage is empty. Each result
// passes through the pipelined arithmetic of each channel: a 33-stage square
// root of the reflectivity, two 42-stage dividers for the index bounds, three
// stages of blend and products, a 51-stage divider for the squared extinction,
// one stage to floor it at zero, a 33-stage square root for the extinction,
// the channel output register and the output register. A stalled sink
// freezes the pipeline once the skid stage has caught the beat in flight;
// nothing is lost or repeated.
module artistic_complex_ior (
    input  logic      clk,
    input  logic      rst_n,
    aci_in_if.sink    material,
    aci_out_if.source ior
);
    import aci_pkg::*;

    logic      en;
    logic      v_red;
    logic      v_green;
    logic      v_blue;
    ior_item_t item;

    assign material.ready = en;

    aci_chan u_chan_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (material.valid),
        .reflect   (material.reflect_red),
        .tint      (material.edge_red),
        .out_valid (v_red),
        .index     (item.index_red),
        .extinct   (item.extinct_red)
    );

    aci_chan u_chan_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (material.valid),
        .reflect   (material.reflect_green),
        .tint      (material.edge_green),
        .out_valid (v_green),
        .index     (item.index_green),
        .extinct   (item.extinct_green)
    );

    aci_chan u_chan_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (material.valid),
        .reflect   (material.reflect_blue),
        .tint      (material.edge_blue),
        .out_valid (v_blue),
        .index     (item.index_blue),
        .extinct   (item.extinct_blue)
    );

    aci_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v_red & v_green & v_blue),
        .up_item  (item),
        .up_ready (en),
        .dn       (ior)
    );

    // channels advance in lockstep
    a_chan_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (v_red == v_green) && (v_green == v_blue))
        else $error("colour channel pipelines out of step");

endmodule
`default_nettype wire
